// ===== src/sequenced_frame_fifo_with_loss_check_defines.svh =====
// Assertion macros shared by the frame buffer RTL.
`ifndef SEQUENCED_FRAME_FIFO_WITH_LOSS_CHECK_DEFINES_SVH
`define SEQUENCED_FRAME_FIFO_WITH_LOSS_CHECK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFFL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sffl_pkg.sv =====
package sffl_pkg;

    localparam int STORE_DEPTH = 2048;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int LIMIT_W     = 11;
    localparam int CMP_W       = (LIMIT_W > PTR_W) ? LIMIT_W : PTR_W;
    localparam int FRAME_W     = 31;
    localparam int IN_W        = 32;
    localparam int FILL_W      = 11;
    localparam int OUT_W       = 80;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2000);

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]         pad;
        logic [FILL_W-1:0]  fill_count;
        logic [FRAME_W-1:0] previous_evicted;
        logic               gap_seen;
        logic [FRAME_W-1:0] evicted_frame;
        logic               evicted;
        logic               accepted;
    } result_t;

endpackage

// ===== src/sequenced_frame_fifo_with_loss_check.sv =====
// Sequenced frame buffer with loss check.
// Input stream (s_*): one 32-bit signed frame number per word. A number is
// stored only if it is positive and, when the buffer holds frames, greater
// than the newest stored number; anything else is dropped but still yields
// a result word. Output stream (m_*): one result word per input word, in
// order. When storing pushes the fill count past buffer_limit, the oldest
// frame is evicted and compared with the previous eviction; gap_seen flags
// a break in the sequence.
// Config channel (cfg_*): writes buffer_limit; always ready. Write it only
// while no word is in flight.
// Pipeline: the result word passes through the input register, then the result
// register. Throughput: one word per cycle while m_tready is high; the append
// and the head eviction each touch one fixed store entry, and the oldest
// entry is prefetched from the store's registered read port.
// Reset: buffer empty, previous eviction 0, limit 2000. The store itself is
// not cleared; only written entries are ever read.
// Receiver stall: the result register holds, the input register fills, and
// then s_tready drops until m_tready returns.
module sequenced_frame_fifo_with_loss_check
    import sffl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,   // [31:0] frame_number
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,   // [0] accepted, [1] evicted,
                                          // [32:2] evicted_frame, [33] gap_seen,
                                          // [64:34] previous_evicted,
                                          // [75:65] fill_count, [79:76] zero
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data   // buffer_limit
);

`include "sequenced_frame_fifo_with_loss_check_defines.svh"

    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W+1)'(STORE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(STORE_DEPTH - 1);
    localparam logic [CMP_W-1:0] LIMIT_MAX = CMP_W'(STORE_DEPTH - 1);

    // Configuration
    logic [LIMIT_W-1:0] limit_reg;

    // Input register
    logic               in_valid_reg;
    logic [IN_W-1:0]    in_data_reg;

    // Buffer state
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   count_reg, count_next;
    logic [FRAME_W-1:0] newest_reg;
    logic [FRAME_W-1:0] last_ev_reg;

    // Store and head prefetch
    logic [FRAME_W-1:0] frame_store [STORE_DEPTH];
    logic [FRAME_W-1:0] rd_data_reg;
    logic               byp_reg;
    logic [FRAME_W-1:0] byp_data_reg;
    logic [FRAME_W-1:0] head_data;

    // Result register
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            out_next;

    // Per-word decision
    logic               advance;
    logic               positive;
    logic               accept;
    logic               evict;
    logic [FRAME_W-1:0] frame_in;
    logic [PTR_W:0]     tail_sum;
    logic [PTR_W-1:0]   tail;
    logic [CMP_W-1:0]   limit_ext;
    logic [CMP_W-1:0]   limit_eff;
    logic [FRAME_W-1:0] ev_frame;
    logic               store_wr;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    assign frame_in  = in_data_reg[FRAME_W-1:0];
    assign positive  = (in_data_reg != '0) && !in_data_reg[IN_W-1];
    assign accept    = positive && ((count_reg == '0) || (frame_in > newest_reg));

    // Saturate the limit at the last index the store can hold
    assign limit_ext = CMP_W'(limit_reg);
    assign limit_eff = (limit_ext > LIMIT_MAX) ? LIMIT_MAX : limit_ext;
    // count + 1 > limit, without growing the count
    assign evict     = accept && (CMP_W'(count_reg) >= limit_eff);

    assign tail_sum  = {1'b0, head_reg} + {1'b0, count_reg};
    assign tail      = (tail_sum >= DEPTH_EXT) ? PTR_W'(tail_sum - DEPTH_EXT)
                                               : tail_sum[PTR_W-1:0];
    assign store_wr  = advance && accept;

    // Prefetched oldest entry; bypass covers a write that landed on it
    assign head_data = byp_reg ? byp_data_reg : rd_data_reg;
    // Empty buffer with a zero limit: the new frame leaves at once
    assign ev_frame  = (count_reg == '0) ? frame_in : head_data;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (advance && evict)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        if (advance && accept && !evict)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_next                  = '0;
        out_next.accepted         = accept;
        out_next.evicted          = evict;
        out_next.evicted_frame    = evict ? ev_frame : '0;
        out_next.previous_evicted = evict ? last_ev_reg : '0;
        out_next.gap_seen         = evict &&
            ({1'b0, last_ev_reg} != ({1'b0, ev_frame} - 1'b1));
        out_next.fill_count       = FILL_W'(accept ? count_next : count_reg);
    end

    // Store: append at the tail, read the entry that will be oldest next cycle
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            frame_store[tail] <= frame_in;
        end
        rd_data_reg  <= frame_store[head_next];
        byp_data_reg <= frame_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            in_valid_reg  <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            newest_reg    <= '0;
            last_ev_reg   <= '0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end

            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            head_reg  <= head_next;
            count_reg <= count_next;
            byp_reg   <= store_wr && (tail == head_next);

            if (advance && accept)
            begin
                newest_reg <= frame_in;
            end
            if (advance && evict)
            begin
                last_ev_reg <= ev_frame;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load without reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    `SFFL_ASSERT_SAME(a_evict_needs_accept, clk, rst_n,
        out_valid_reg && out_reg.evicted, out_reg.accepted,
        "eviction reported for a dropped frame")
    `SFFL_ASSERT_NEXT(a_drop_keeps_state, clk, rst_n,
        advance && !accept, $stable(count_reg) && $stable(head_reg),
        "dropped frame changed buffer state")
    `SFFL_ASSERT_NEXT(a_append_grows, clk, rst_n,
        advance && accept && !evict, count_reg == $past(count_reg) + 1'b1,
        "append without eviction did not grow the fill count")
    `SFFL_ASSERT_NEXT(a_input_held, clk, rst_n,
        in_valid_reg && !advance, in_valid_reg && $stable(in_data_reg),
        "stalled input register lost its word")

endmodule

// ===== test/frame_buffer_checker.sv =====
module frame_buffer_checker
    import sffl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [OUT_W-1:0]   m_tdata,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,
    output int                 failures,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the frame buffer.
    logic [FRAME_W-1:0] frames [STORE_DEPTH];
    logic [PTR_W-1:0]   oldest;
    logic [PTR_W:0]     held;
    logic [FRAME_W-1:0] newest;
    logic [FRAME_W-1:0] prior_evicted;
    logic [LIMIT_W-1:0] limit;

    result_t frame_verdicts[$];

    // Store the frame if it is in sequence, evict the oldest on overflow.
    task automatic admit_frame(input logic [IN_W-1:0] number, output result_t res);
        logic [PTR_W:0]   cap;
        logic [PTR_W-1:0] tail;
        logic             positive;
        res = '0;
        cap = (PTR_W+1)'(limit);
        if (cap > STORE_DEPTH - 1)
            cap = (PTR_W+1)'(STORE_DEPTH - 1);
        positive = !number[IN_W-1] && (number != '0);
        if (positive && (held == 0 || number[FRAME_W-1:0] > newest))
        begin
            tail = oldest + held[PTR_W-1:0];
            frames[tail] = number[FRAME_W-1:0];
            newest = number[FRAME_W-1:0];
            held++;
            res.accepted = 1'b1;
            if (held > cap)
            begin
                res.evicted = 1'b1;
                res.evicted_frame = frames[oldest];
                res.previous_evicted = prior_evicted;
                res.gap_seen = (prior_evicted != res.evicted_frame - 1'b1);
                prior_evicted = res.evicted_frame;
                oldest++;
                held--;
            end
        end
        res.fill_count = held[FILL_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t fresh;
        result_t want;
        result_t seen;
        if (!rst_n)
        begin
            oldest = '0;
            held = '0;
            newest = '0;
            prior_evicted = '0;
            limit = LIMIT_RESET;
            frame_verdicts.delete();
            failures = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit = cfg_data;
            if (m_tvalid && m_tready)
            begin
                seen = result_t'(m_tdata);
                if (frame_verdicts.size() == 0)
                begin
                    $error("result word %0h with no frame pending", m_tdata);
                    failures++;
                end
                else
                begin
                    want = frame_verdicts.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(seen.accepted));
                    check_field("evicted", 32'(want.evicted), 32'(seen.evicted));
                    check_field("evicted_frame", 32'(want.evicted_frame),
                                32'(seen.evicted_frame));
                    check_field("gap_seen", 32'(want.gap_seen), 32'(seen.gap_seen));
                    check_field("previous_evicted", 32'(want.previous_evicted),
                                32'(seen.previous_evicted));
                    check_field("fill_count", 32'(want.fill_count),
                                32'(seen.fill_count));
                    check_field("pad", 32'(want.pad), 32'(seen.pad));
                end
            end
            if (s_tvalid && s_tready)
            begin
                admit_frame(s_tdata, fresh);
                frame_verdicts = {frame_verdicts, fresh};
            end
        end
        outstanding = frame_verdicts.size();
    end

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sffl_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;    // [31:0] frame_number
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;    // [0] accepted, [1] evicted, [32:2] evicted_frame,
                                    // [33] gap_seen, [64:34] previous_evicted,
                                    // [75:65] fill_count, [79:76] zero
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;   // buffer_limit

    int failures;
    int outstanding;

    // Sender pacing and the running frame sequence.
    int          burst_left;
    logic [31:0] next_frame;

    // Opening words, run with a limit of zero so the buffer is empty at every word:
    // zero, minus one and the most negative number are dropped, the largest number
    // is kept and evicted, then smaller numbers are still kept because nothing
    // is held, a repeated number included.
    logic [31:0] empty_frames [10] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1,
        32'd2, 32'd5, 32'd3, 32'd3, 32'd4
    };

    // With a limit of three: an older and an equal number are dropped, the fourth
    // stored frame pushes out the oldest (a gap after 4), then a clean run, a
    // jump, and a negative number.
    logic [31:0] short_frames [9] = '{
        32'd10, 32'd11, 32'd9, 32'd11, 32'd12, 32'd13, 32'd14, 32'd20, 32'h8000_0001
    };

    sequenced_frame_fifo_with_loss_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    frame_buffer_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Write the limit register; the caller has already drained the block.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Offer one word, inserting an idle gap between most bursts. Valid stays high
    // from one word to the next inside a burst.
    task automatic send_frame(input logic [IN_W-1:0] number);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = number;
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop valid and hold until every result word is back.
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    // Mostly the next number in sequence; now and then a skip, a big jump,
    // a stale or repeated number, or a non-positive one.
    function automatic logic [31:0] pick_frame();
        int          roll;
        logic [31:0] pick;
        roll = $urandom_range(99, 0);
        if (roll < 6)
        begin
            if ($urandom_range(1, 0) == 0)
                return 32'h0;
            return {1'b1, 31'($urandom)};
        end
        if (roll < 11 && next_frame > 5)
            return next_frame - $urandom_range(4, 1);
        if (roll < 17)
            next_frame += $urandom_range(40, 2);
        else if (roll < 18 && next_frame < 32'h4000_0000)
            next_frame += $urandom_range(1 << 20, 1 << 12);
        pick = next_frame;
        next_frame++;
        return pick;
    endfunction

    // Receiver: stretches of always-ready, coin-flip and mostly-stalled, plus two
    // long hold-offs that back the block up until it stalls its input.
    initial
    begin
        int cyc;
        int stretch;
        int mode;
        int hold;
        cyc = 0;
        stretch = 0;
        mode = 0;
        hold = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc == 700 || cyc == 2000)
                hold = 150;
            if (hold > 0)
            begin
                hold--;
                m_tready = 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    stretch = $urandom_range(200, 20);
                    mode = $urandom_range(2, 0);
                end
                stretch--;
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(1, 0));
                    default: m_tready = ($urandom_range(3, 0) == 0);
                endcase
            end
        end
    end

    initial
    begin
        logic [LIMIT_W-1:0] lim;
        int                 words;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        burst_left = 0;
        next_frame = 32'd21;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_limit(11'd0);
        foreach (empty_frames[i])
            send_frame(empty_frames[i]);
        settle();
        write_limit(11'd3);
        foreach (short_frames[i])
            send_frame(short_frames[i]);
        settle();

        // Random phases. The fill count never shrinks once frames are held, so
        // the small limits come first; the large ones let the store fill deep.
        // The last phase moves the sequence near the top.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    lim = 11'd1;
                    words = 200;
                end
                1:
                begin
                    lim = 11'($urandom_range(12, 2));
                    words = 200;
                end
                2:
                begin
                    lim = 11'd0;
                    words = 100;
                end
                3:
                begin
                    lim = 11'($urandom_range(300, 13));
                    words = 230;
                end
                4:
                begin
                    lim = 11'd2047;
                    words = 600;
                end
                default:
                begin
                    lim = LIMIT_RESET;
                    words = 200;
                    next_frame = 32'h7FFF_0000;
                end
            endcase
            write_limit(lim);
            repeat (words)
                send_frame(pick_frame());
            settle();
        end

        // Let the pipeline empty before the verdict.
        repeat (20) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
